// ===== rtl/ejt_pkg.sv =====
// Shared types and constants of the EUC-JP transcoder.
`default_nettype none
package ejt_pkg;

    localparam int RUN_MAX = 5;

    localparam logic [1:0] CFG_OUTPUT_MODE = 2'd0;
    localparam logic [1:0] CFG_KANJI_FINAL = 2'd1;
    localparam logic [1:0] CFG_ASCII_FINAL = 2'd2;

    localparam logic [6:0] FINAL_RESET = 7'd66;

    localparam logic [7:0] SS2_BYTE  = 8'h8E;
    localparam logic [7:0] ESC_BYTE  = 8'h1B;
    localparam logic [7:0] MID_KANJI = 8'h24;
    localparam logic [7:0] MID_ASCII = 8'h28;
    localparam logic [7:0] NUL_BYTE  = 8'h00;

    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_SS2   = 2'd1;
    localparam logic [1:0] PEND_KANJI = 2'd2;

    // One run is every output word caused by one input word, first word in slot 0.
    typedef struct packed {
        logic [2:0]                len;
        logic [RUN_MAX-1:0][7:0]   bytes;
    } t_run;

endpackage
`default_nettype wire

// ===== rtl/euc_jp_transcoder_core.sv =====
// Top level of the EUC-JP to JIS / Shift-JIS transcoder.
//
//  channel   direction  handshake                 payload
//  input     in         i_in_valid / o_in_stall   i_in_byte
//  output    out        o_out_valid / i_out_stall o_out_byte, o_out_last_of_run
//  config    in         i_cfg_we                  i_cfg_index, i_cfg_data
//
// An input word is taken whenever the input is not stalled; its run of zero to five
// output words leaves the output register at one word per cycle while i_out_stall is low.
// Input stalls only when the run queue (QUEUE_DEPTH runs) is full, so runs with
// escape sequences throttle the input while the sequencer drains them.
// Synchronous active-low reset clears the lead state, the queue and the output
// register, and returns the configuration to JIS mode with final byte 'B'.
`default_nettype none
module euc_jp_transcoder_core
    import ejt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [7:0] i_in_byte,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last_of_run
);

    logic in_accept;
    logic push;
    logic pop;
    logic full;
    logic empty;
    t_run run;
    t_run head;

    assign o_in_stall = full;
    assign in_accept  = i_in_valid && !full;

    ejt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_byte      (i_in_byte),
        .o_push      (push),
        .o_run       (run)
    );

    ejt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (run),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    ejt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last_of_run)
    );

endmodule
`default_nettype wire

// ===== rtl/ejt_front.sv =====
// Front end: configuration, lead-byte state and building of output runs.
`default_nettype none
module ejt_front
    import ejt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [6:0] i_cfg_data,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    output logic            o_push,
    output t_run            o_run
);

    logic       r_mode;
    logic [6:0] r_kanji_final;
    logic [6:0] r_ascii_final;
    logic [7:0] r_held_lead;
    logic [1:0] r_pending;
    logic       r_kanji_des;

    logic [7:0] n_held_lead;
    logic [1:0] n_pending;
    logic       n_kanji_des;

    logic [6:0] c1;
    logic [6:0] c2;
    logic [7:0] dif;
    logic [7:0] half;
    logic [7:0] s1;
    logic [7:0] s2;

    // Shift-JIS arithmetic; the halving truncates toward zero for low leads.
    always_comb begin
        c1   = r_held_lead[6:0];
        c2   = i_byte[6:0];
        dif  = {1'b0, c1} - 8'h21 + {7'd0, (c1 < 7'h21)};
        half = {dif[7], dif[7:1]};
        s1   = half + ((c1 <= 7'h5E) ? 8'h81 : 8'hC1);
        if (c1[0]) begin
            s2 = {1'b0, c2} + ((c2 <= 7'h5F) ? 8'h1F : 8'h20);
        end else begin
            s2 = {1'b0, c2} + 8'h7E;
        end
    end

    always_comb begin
        n_held_lead = r_held_lead;
        n_pending   = r_pending;
        n_kanji_des = r_kanji_des;
        o_run       = '0;
        if (i_byte == NUL_BYTE) begin
            if (!r_mode && r_kanji_des) begin
                o_run.bytes[0] = ESC_BYTE;
                o_run.bytes[1] = MID_ASCII;
                o_run.bytes[2] = {1'b0, r_ascii_final};
                o_run.bytes[3] = NUL_BYTE;
                o_run.len      = 3'd4;
            end else begin
                o_run.bytes[0] = NUL_BYTE;
                o_run.len      = 3'd1;
            end
            n_held_lead = '0;
            n_pending   = PEND_NONE;
            n_kanji_des = 1'b0;
        end else if (r_pending == PEND_SS2) begin
            o_run.bytes[0] = i_byte | 8'h80;
            o_run.len      = 3'd1;
            n_held_lead    = '0;
            n_pending      = PEND_NONE;
        end else if (r_pending == PEND_KANJI) begin
            if (r_mode) begin
                o_run.bytes[0] = s1;
                o_run.bytes[1] = s2;
                o_run.len      = 3'd2;
            end else if (!r_kanji_des) begin
                o_run.bytes[0] = ESC_BYTE;
                o_run.bytes[1] = MID_KANJI;
                o_run.bytes[2] = {1'b0, r_kanji_final};
                o_run.bytes[3] = {1'b0, c1};
                o_run.bytes[4] = {1'b0, c2};
                o_run.len      = 3'd5;
                n_kanji_des    = 1'b1;
            end else begin
                o_run.bytes[0] = {1'b0, c1};
                o_run.bytes[1] = {1'b0, c2};
                o_run.len      = 3'd2;
            end
            n_held_lead = '0;
            n_pending   = PEND_NONE;
        end else if (i_byte == SS2_BYTE) begin
            n_held_lead = i_byte;
            n_pending   = PEND_SS2;
        end else if (i_byte[7]) begin
            n_held_lead = i_byte;
            n_pending   = PEND_KANJI;
        end else begin
            n_pending = PEND_NONE;
            if (!r_mode && r_kanji_des) begin
                o_run.bytes[0] = ESC_BYTE;
                o_run.bytes[1] = MID_ASCII;
                o_run.bytes[2] = {1'b0, r_ascii_final};
                o_run.bytes[3] = i_byte;
                o_run.len      = 3'd4;
                n_kanji_des    = 1'b0;
            end else begin
                o_run.bytes[0] = i_byte;
                o_run.len      = 3'd1;
            end
        end
    end

    assign o_push = i_accept && (o_run.len != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= 1'b0;
            r_kanji_final <= FINAL_RESET;
            r_ascii_final <= FINAL_RESET;
            r_held_lead   <= '0;
            r_pending     <= PEND_NONE;
            r_kanji_des   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OUTPUT_MODE: r_mode        <= i_cfg_data[0];
                    CFG_KANJI_FINAL: r_kanji_final <= i_cfg_data;
                    CFG_ASCII_FINAL: r_ascii_final <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_accept) begin
                r_held_lead <= n_held_lead;
                r_pending   <= n_pending;
                r_kanji_des <= n_kanji_des;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/ejt_queue.sv =====
// Short run queue between the front end and the output sequencer.
`default_nettype none
module ejt_queue
    import ejt_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_run      i_run,
    input  wire logic i_pop,
    output logic      o_full,
    output logic      o_empty,
    output t_run      o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    t_run          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_SLOT) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_SLOT) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("run pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("run popped from an empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== rtl/ejt_back.sv =====
// Output sequencer: walks the head run one word per cycle into the output register, unless the output is stalled.
`default_nettype none
module ejt_back
    import ejt_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_empty,
    input  t_run            i_head,
    output logic            o_pop,
    input  wire logic       i_out_stall,
    output logic            o_out_valid,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last
);

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;
    logic [2:0] r_pos;

    logic load;
    logic at_end;

    assign load   = !i_empty && (!r_out_valid || !i_out_stall);
    assign at_end = (r_pos == (i_head.len - 3'd1));
    assign o_pop  = load && at_end;

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_byte <= i_head.bytes[r_pos];
            r_out_last <= at_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_pos       <= at_end ? 3'd0 : r_pos + 3'd1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_pos_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_empty |-> (r_pos < i_head.len))
        else $error("word position past the end of the head run");
    a_pos_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_empty |-> (r_pos == 3'd0))
        else $error("word position left mid-run with no run queued");
`endif

endmodule
`default_nettype wire

// ===== tb/euc_jp_transcoder_checker.sv =====
// Checker that predicts and compares the output words of the EUC-JP transcoder.
module euc_jp_transcoder_checker
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_errors,
    output int         o_waiting,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import ejt_pkg::*;

    localparam int ROW_OFFSET   = 'h21;
    localparam int ROW_SPLIT    = 'h5e;
    localparam int LOW_BASE     = 'h81;
    localparam int HIGH_BASE    = 'hc1;
    localparam int CELL_SPLIT   = 'h5f;
    localparam int CELL_LOW_ADD = 'h1f;
    localparam int CELL_HI_ADD  = 'h20;
    localparam int CELL_EVEN    = 'h7e;
    localparam int PRINT_CAP    = 40;

    // Expected output words, oldest first.
    logic [7:0] exp_bytes[$];
    logic       exp_last[$];

    // Configuration and decoder state as the block should hold them.
    logic       sjis_mode;
    logic [6:0] kanji_final;
    logic [6:0] ascii_final;
    logic [7:0] lead_byte;
    logic [1:0] lead_kind;
    logic       kanji_shift;

    // Words of the run being built for the current input word.
    logic [7:0] run_buf[RUN_MAX];
    int         run_len;

    task automatic report_mismatch(input string what);
        if (o_errors < PRINT_CAP)
            $display("%0t ns: mismatch: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic void emit_byte(input logic [7:0] b);
        run_buf[run_len] = b;
        run_len++;
    endfunction

    function automatic void emit_escape(input logic [7:0] mid, input logic [6:0] fin);
        emit_byte(ESC_BYTE);
        emit_byte(mid);
        emit_byte({1'b0, fin});
    endfunction

    function automatic void transcode_word(input logic [7:0] b);
        int c1;
        int c2;
        int s1;
        int s2;
        run_len = 0;
        if (b == NUL_BYTE) begin
            if (!sjis_mode && kanji_shift)
                emit_escape(MID_ASCII, ascii_final);
            emit_byte(NUL_BYTE);
            lead_byte   = 8'd0;
            lead_kind   = PEND_NONE;
            kanji_shift = 1'b0;
        end else if (lead_kind == PEND_SS2) begin
            emit_byte(b | 8'h80);
            lead_byte = 8'd0;
            lead_kind = PEND_NONE;
        end else if (lead_kind == PEND_KANJI) begin
            c1 = int'(lead_byte[6:0]);
            c2 = int'(b[6:0]);
            if (sjis_mode) begin
                // Signed division so that low leads truncate toward zero.
                s1 = (c1 - ROW_OFFSET) / 2 + ((c1 <= ROW_SPLIT) ? LOW_BASE : HIGH_BASE);
                if (c1 % 2 == 1)
                    s2 = c2 + ((c2 <= CELL_SPLIT) ? CELL_LOW_ADD : CELL_HI_ADD);
                else
                    s2 = c2 + CELL_EVEN;
                emit_byte(s1[7:0]);
                emit_byte(s2[7:0]);
            end else begin
                if (!kanji_shift) begin
                    emit_escape(MID_KANJI, kanji_final);
                    kanji_shift = 1'b1;
                end
                emit_byte({1'b0, lead_byte[6:0]});
                emit_byte({1'b0, b[6:0]});
            end
            lead_byte = 8'd0;
            lead_kind = PEND_NONE;
        end else if (b == SS2_BYTE) begin
            lead_byte = b;
            lead_kind = PEND_SS2;
        end else if (b[7]) begin
            lead_byte = b;
            lead_kind = PEND_KANJI;
        end else begin
            lead_kind = PEND_NONE;
            if (!sjis_mode && kanji_shift) begin
                emit_escape(MID_ASCII, ascii_final);
                kanji_shift = 1'b0;
            end
            emit_byte(b);
        end
        for (int k = 0; k < run_len; k++) begin
            exp_bytes.push_back(run_buf[k]);
            exp_last.push_back(k == run_len - 1);
        end
    endfunction

    task automatic check_word();
        logic [7:0] want_byte;
        logic       want_last;
        if (exp_bytes.size() == 0) begin
            report_mismatch($sformatf("output word %h with nothing expected", i_out_byte));
        end else begin
            want_byte = exp_bytes.pop_front();
            want_last = exp_last.pop_front();
            if (i_out_byte !== want_byte)
                report_mismatch($sformatf("word %0d: byte %h, expected %h",
                                          o_checked, i_out_byte, want_byte));
            if (i_out_last !== want_last)
                report_mismatch($sformatf("word %0d: last_of_run %b, expected %b",
                                          o_checked, i_out_last, want_last));
        end
        o_checked++;
    endtask

    initial begin
        o_errors  = 0;
        o_checked = 0;
        o_waiting = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sjis_mode   = 1'b0;
            kanji_final = FINAL_RESET;
            ascii_final = FINAL_RESET;
            lead_byte   = 8'd0;
            lead_kind   = PEND_NONE;
            kanji_shift = 1'b0;
            exp_bytes.delete();
            exp_last.delete();
        end else begin
            // Outputs first, so a word leaving now is never matched to an input taken now.
            if (i_out_valid && !i_out_stall)
                check_word();
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OUTPUT_MODE: sjis_mode   = i_cfg_data[0];
                    CFG_KANJI_FINAL: kanji_final = i_cfg_data;
                    CFG_ASCII_FINAL: ascii_final = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                transcode_word(i_in_byte);
        end
        o_waiting <= exp_bytes.size();
    end

endmodule

// ===== tb/euc_jp_transcoder_core_tb.sv =====
// Testbench top of the EUC-JP transcoder: stimulus, stalls and verdict.
module euc_jp_transcoder_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ejt_pkg::*;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_CYCLES    = 90;
    localparam int RANDOM_WORDS   = 28;

    localparam logic [7:0] JIS_WORDS [16] = '{
        8'h7F, 8'h01, 8'hB0, 8'hA1, 8'hFF, 8'hFE, 8'h20, 8'h8E,
        8'h8E, 8'h8E, 8'h05, 8'hC6, 8'h05, 8'h00, 8'hA4, 8'h00
    };
    localparam logic [7:0] SJIS_WORDS [13] = '{
        8'h80, 8'hA0, 8'hA0, 8'h20, 8'hB1, 8'hDF, 8'hDE, 8'h8E,
        8'hDF, 8'hE0, 8'hFF, 8'hFF, 8'h00
    };

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_we    = 1'b0;
    logic [1:0] i_cfg_index = CFG_OUTPUT_MODE;
    logic [6:0] i_cfg_data  = 7'd0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'd0;
    logic       i_out_stall = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [7:0] o_out_byte;
    logic       o_out_last_of_run;

    int errors;
    int waiting;
    int checked;
    int words_sent   = 0;
    int cfg_writes   = 0;
    int settings_run = 0;
    int cycle_count  = 0;
    bit idle_on      = 1'b1;
    bit hold_off     = 1'b0;

    euc_jp_transcoder_core i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_in_byte         (i_in_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_out_byte        (o_out_byte),
        .o_out_last_of_run (o_out_last_of_run)
    );

    euc_jp_transcoder_checker i_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_byte   (i_in_byte),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_byte  (o_out_byte),
        .i_out_last  (o_out_last_of_run),
        .o_errors    (errors),
        .o_waiting   (waiting),
        .o_checked   (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still expected", cycle_count, waiting);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always begin
        @(posedge i_clk);
        if (hold_off) begin
            i_out_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge i_clk);
            i_out_stall <= 1'b0;
            hold_off = 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
            i_out_stall <= 1'b0;
        end
    end

    // Valid stays high into the next word unless a gap is taken.
    task automatic send_word(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        words_sent++;
    endtask

    // A lead word produces nothing, so the block may still be draining after the
    // last expected word has left; the extra cycles cover that.
    task automatic settle();
        i_in_valid <= 1'b0;
        do
            @(negedge i_clk);
        while (waiting != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic mode, input logic [6:0] kfin, input logic [6:0] afin);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OUTPUT_MODE;
        i_cfg_data  <= {6'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_KANJI_FINAL;
        i_cfg_data  <= kfin;
        @(posedge i_clk);
        i_cfg_index <= CFG_ASCII_FINAL;
        i_cfg_data  <= afin;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes += 3;
        settings_run++;
    endtask

    // Mostly well-formed characters with random content, some noise.
    task automatic send_random_sequence();
        int         pick;
        logic [7:0] lead;
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            send_word(8'($urandom_range(1, 127)));
        end else if (pick < 65) begin
            lead = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
                                               : 8'($urandom_range(161, 254));
            if (lead == SS2_BYTE)
                lead = 8'h80;
            send_word(lead);
            send_word(($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(161, 254)));
        end else if (pick < 80) begin
            send_word(SS2_BYTE);
            send_word(($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(161, 223)));
        end else if (pick < 90) begin
            send_word(NUL_BYTE);
        end else if (pick < 95) begin
            send_word(8'($urandom_range(128, 255)));
            send_word(NUL_BYTE);
        end else begin
            send_word(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic run_random(input int count);
        int first;
        first = words_sent;
        while (words_sent - first < count)
            send_random_sequence();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // JIS output with the reset settings.
        settings_run = 1;
        for (int k = 0; k < $size(JIS_WORDS); k++)
            send_word(JIS_WORDS[k]);
        settle();

        set_config(1'b1, FINAL_RESET, FINAL_RESET);
        for (int k = 0; k < $size(SJIS_WORDS); k++)
            send_word(SJIS_WORDS[k]);
        settle();

        set_config(1'b0, 7'd48, 7'd126);
        run_random(RANDOM_WORDS);
        settle();

        // Long receiver hold-off while escape-heavy JIS runs keep arriving.
        set_config(1'b0, 7'd126, 7'd48);
        hold_off = 1'b1;
        run_random(RANDOM_WORDS);
        settle();

        set_config(1'b1, 7'd127, 7'd0);
        run_random(RANDOM_WORDS);
        settle();

        set_config(1'b0, 7'd0, 7'd127);
        run_random(RANDOM_WORDS);
        settle();

        idle_on = 1'b0;
        set_config(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                   7'($urandom_range(0, 127)));
        run_random(RANDOM_WORDS);
        settle();

        $display("coverage: %0d input words over %0d settings, %0d register writes",
                 words_sent, settings_run, cfg_writes);
        $display("coverage: %0d output words compared, %0d mismatches, %0d cycles",
                 checked, errors, cycle_count);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
